/* src/tpfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpfr_pkg
// shared types, codes and the crc step of the typed packet frame receiver
// ----------------------------------------------------------------------------
package tpfr_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 256;

    localparam logic [7:0]  HDR_FIRST  = 8'hA5;
    localparam logic [7:0]  HDR_SECOND = 8'h5A;
    localparam logic [7:0]  TAIL_BYTE  = 8'hFF;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_LEN_BAD  = 3'd2;
    localparam logic [2:0] ST_CMD_BAD  = 3'd3;
    localparam logic [2:0] ST_CRC_BAD  = 3'd4;

    localparam logic [2:0] TYPE_BOOL  = 3'd0;
    localparam logic [2:0] TYPE_INT8  = 3'd1;
    localparam logic [2:0] TYPE_INT16 = 3'd2;
    localparam logic [2:0] TYPE_INT32 = 3'd3;
    localparam logic [2:0] TYPE_FP32  = 3'd4;

    localparam logic [2:0] REG_EXPECTED_COMMAND = 3'd0;
    localparam logic [2:0] REG_BOOL_COUNT       = 3'd1;
    localparam logic [2:0] REG_BYTE_COUNT       = 3'd2;
    localparam logic [2:0] REG_HALF_COUNT       = 3'd3;
    localparam logic [2:0] REG_WORD_COUNT       = 3'd4;
    localparam logic [2:0] REG_FLOAT_COUNT      = 3'd5;

    localparam logic [0:0] KIND_BYTE = 1'b0;
    localparam logic [0:0] KIND_READ = 1'b1;

    typedef struct packed {
        logic [0:0]  kind;
        logic [7:0]  rx_byte;
        logic [2:0]  elem_type;
        logic [10:0] elem_index;
    } tpfr_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value;
        logic               in_range;
    } tpfr_out_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* src/tpfr_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpfr_parser
// header hunt, length/command checks, payload crc and bank selection
// ----------------------------------------------------------------------------
module tpfr_parser #(
    parameter int PAYLOAD_DEPTH = tpfr_pkg::PAYLOAD_DEPTH_DEF,
    parameter int AW            = $clog2(2 * PAYLOAD_DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [10:0]   req_len,
    input  wire logic [7:0]    expected_command,
    output logic      [2:0]    status,
    output logic               wr_en,
    output logic      [AW-1:0] wr_addr,
    output logic      [7:0]    wr_data,
    output logic               accepted_bank
);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_HDR2  = 2'd1;
    localparam logic [1:0] PH_FRAME = 2'd2;
    localparam logic [AW-1:0] BANK_OFS = AW'(PAYLOAD_DEPTH);
    localparam logic [8:0]    DEPTH9   = 9'(PAYLOAD_DEPTH);

    logic [1:0]  phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crch_reg, crch_next;
    logic        bank_reg, bank_next;
    logic [8:0]  off;

    assign off           = pos_reg - 9'd4;
    assign accepted_bank = bank_reg;
    assign wr_data       = rx_byte;
    assign wr_addr       = (bank_reg ? '0 : BANK_OFS) + off[AW-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        crc_next   = crc_reg;
        crch_next  = crch_reg;
        bank_next  = bank_reg;
        status     = tpfr_pkg::ST_NONE;
        wr_en      = 1'b0;
        if (byte_valid)
        begin
            if (phase_reg == PH_HDR2 && rx_byte == tpfr_pkg::HDR_SECOND)
            begin
                phase_next = PH_FRAME;
                pos_next   = 9'd2;
                crc_next   = tpfr_pkg::CRC_INIT;
            end
            else if (phase_reg != PH_FRAME)
            begin
                // wrong second header byte is re-examined as a first one
                phase_next = (rx_byte == tpfr_pkg::HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
            else if (pos_reg == 9'd2)
            begin
                len_next = rx_byte;
                if (req_len != {3'b000, rx_byte})
                begin
                    status     = tpfr_pkg::ST_LEN_BAD;
                    phase_next = PH_HUNT;
                    pos_next   = '0;
                    crc_next   = tpfr_pkg::CRC_INIT;
                end
                else
                begin
                    pos_next = 9'd3;
                end
            end
            else if (pos_reg == 9'd3)
            begin
                cmd_next = rx_byte;
                pos_next = 9'd4;
            end
            else
            begin
                pos_next = pos_reg + 9'd1;
                if (off < {1'b0, len_reg})
                begin
                    wr_en    = (off < DEPTH9);
                    crc_next = tpfr_pkg::crc_step(crc_reg, rx_byte);
                end
                else if (off == {1'b0, len_reg})
                begin
                    crch_next = rx_byte;
                end
                else if (off == {1'b0, len_reg} + 9'd1)
                begin
                    crc_next = crc_reg ^ {crch_reg, rx_byte};
                end
                else
                begin
                    if (cmd_reg != expected_command)
                        status = tpfr_pkg::ST_CMD_BAD;
                    else if (crc_reg != 16'h0000 || rx_byte != tpfr_pkg::TAIL_BYTE)
                        status = tpfr_pkg::ST_CRC_BAD;
                    else
                    begin
                        status    = tpfr_pkg::ST_ACCEPTED;
                        bank_next = ~bank_reg;
                    end
                    phase_next = PH_HUNT;
                    pos_next   = '0;
                    crc_next   = tpfr_pkg::CRC_INIT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            len_reg   <= '0;
            cmd_reg   <= '0;
            crc_reg   <= tpfr_pkg::CRC_INIT;
            crch_reg  <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            crc_reg   <= crc_next;
            crch_reg  <= crch_next;
            bank_reg  <= bank_next;
        end
    end

endmodule
`default_nettype wire

/* src/tpfr_payload_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpfr_payload_mem
// two-bank payload store in four byte lanes, any four consecutive bytes per read
// ----------------------------------------------------------------------------
module tpfr_payload_mem #(
    parameter int PAYLOAD_DEPTH = tpfr_pkg::PAYLOAD_DEPTH_DEF,
    parameter int AW            = $clog2(2 * PAYLOAD_DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire logic [7:0]      wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output logic      [3:0][7:0] rd_data
);

    localparam int ROWS = (2 * PAYLOAD_DEPTH + 3) / 4;
    localparam int RW   = $clog2(ROWS);

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        logic [7:0]  lane_mem [0:ROWS-1];
        logic [7:0]  q_reg;
        logic [1:0]  skew;
        logic [AW:0] sum;
        logic [RW-1:0] rrow;

        // lane l holds byte (rd_addr + skew) of the requested run
        assign skew = 2'(l) - rd_addr[1:0];
        assign sum  = {1'b0, rd_addr} + {{(AW-1){1'b0}}, skew};
        assign rrow = sum[RW+1:2];

        always_ff @(posedge clk)
        begin
            if (wr_en && wr_addr[1:0] == 2'(l))
                lane_mem[wr_addr[RW+1:2]] <= wr_data;
            if (rd_en)
                q_reg <= lane_mem[rrow];
        end

        assign rd_data[l] = q_reg;
    end

endmodule
`default_nettype wire

/* src/typed_packet_frame_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// typed_packet_frame_receiver
// frame receiver with crc-16 check and typed element reads of the last frame
// ----------------------------------------------------------------------------
// Usage: each input transaction is either a received serial byte (kind 0) or
// a read of one typed element of the last accepted frame (kind 1). Every input
// transaction yields exactly one output transaction: a status for bytes, a
// value, sign-extended for int8 and int16, and an in_range flag for reads.
// Each input transaction passes the s1 and output registers to out_valid;
// one item is taken every cycle while in_ready is high. The payload store is
// four byte lanes, so a 32-bit element is fetched in one read from each lane.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data,
// always ready; the user must write them only while no item is in flight, which
// the block does not enforce. The section offsets are a five-stage register
// chain, so in_ready stays low after each configuration write until it settles.
// Reset clears all control state, counts and the accepted bank; the payload
// store holds nothing meaningful until a frame has been accepted.
// When out_valid is high and out_ready low the whole pipeline holds and
// in_ready drops in the same cycle, so no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module typed_packet_frame_receiver #(
    parameter int PAYLOAD_DEPTH = tpfr_pkg::PAYLOAD_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tpfr_pkg::tpfr_in_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tpfr_pkg::tpfr_out_t     out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [10:0]        cfg_data
);

    localparam int AW = $clog2(2 * PAYLOAD_DEPTH);
    localparam logic [12:0]   DEPTH13  = 13'(PAYLOAD_DEPTH);
    localparam logic [AW-1:0] BANK_OFS = AW'(PAYLOAD_DEPTH);
    localparam logic [2:0]    CFG_SETTLE = 3'd5;

    logic [7:0]  cmd_reg;
    logic [10:0] bool_cnt_reg;
    logic [7:0]  byte_cnt_reg;
    logic [6:0]  half_cnt_reg;
    logic [5:0]  word_cnt_reg;
    logic [5:0]  float_cnt_reg;
    logic [10:0] req_len_reg;
    logic [10:0] b8_reg, b16_reg, b32_reg, bf_reg;
    logic [2:0]  settle_reg;

    logic            en, accept;
    logic [2:0]      p_status;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            acc_bank;
    logic [3:0][7:0] lane_q;

    logic        rd_ok;
    logic [12:0] rd_off;
    logic [2:0]  nbytes;
    logic [3:0]  rd_mask;
    logic [AW-1:0] rd_addr;

    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [2:0]  s1_status_reg;
    logic        s1_ok_reg;
    logic [2:0]  s1_type_reg;
    logic [2:0]  s1_bit_reg;
    logic [1:0]  s1_lane_reg;
    logic [3:0]  s1_mask_reg;
    logic        out_valid_reg;
    tpfr_pkg::tpfr_out_t out_reg;

    logic [3:0][7:0] bytes_sel;
    logic [31:0]     value_c;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en && (settle_reg == 3'd0);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= '0;
            bool_cnt_reg  <= '0;
            byte_cnt_reg  <= '0;
            half_cnt_reg  <= '0;
            word_cnt_reg  <= '0;
            float_cnt_reg <= '0;
            req_len_reg   <= '0;
            b8_reg        <= '0;
            b16_reg       <= '0;
            b32_reg       <= '0;
            bf_reg        <= '0;
            settle_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tpfr_pkg::REG_EXPECTED_COMMAND: cmd_reg       <= cfg_data[7:0];
                    tpfr_pkg::REG_BOOL_COUNT:       bool_cnt_reg  <= cfg_data;
                    tpfr_pkg::REG_BYTE_COUNT:       byte_cnt_reg  <= cfg_data[7:0];
                    tpfr_pkg::REG_HALF_COUNT:       half_cnt_reg  <= cfg_data[6:0];
                    tpfr_pkg::REG_WORD_COUNT:       word_cnt_reg  <= cfg_data[5:0];
                    tpfr_pkg::REG_FLOAT_COUNT:      float_cnt_reg <= cfg_data[5:0];
                    default: ;
                endcase
            end
            // hold the input off until the offset chain has caught up
            if (cfg_valid && cfg_ready)
                settle_reg <= CFG_SETTLE;
            else if (settle_reg != 3'd0)
                settle_reg <= settle_reg - 3'd1;
            // section offsets and the required length are registered along a chain, each from the one before
            b8_reg      <= {2'b00, 9'(({1'b0, bool_cnt_reg} + 12'd7) >> 3)};
            b16_reg     <= b8_reg + {3'b000, byte_cnt_reg};
            b32_reg     <= b16_reg + {3'b000, half_cnt_reg, 1'b0};
            bf_reg      <= b32_reg + {3'b000, word_cnt_reg, 2'b00};
            req_len_reg <= bf_reg + {3'b000, float_cnt_reg, 2'b00};
        end
    end

    tpfr_parser #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .AW            (AW)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (accept && in_item.kind == tpfr_pkg::KIND_BYTE),
        .rx_byte          (in_item.rx_byte),
        .req_len          (req_len_reg),
        .expected_command (cmd_reg),
        .status           (p_status),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .accepted_bank    (acc_bank)
    );

    // element address generation
    always_comb
    begin
        rd_ok  = 1'b0;
        rd_off = '0;
        nbytes = 3'd0;
        case (in_item.elem_type)
            tpfr_pkg::TYPE_BOOL:
            begin
                rd_ok  = in_item.elem_index < bool_cnt_reg;
                rd_off = {5'b0, in_item.elem_index[10:3]};
                nbytes = 3'd1;
            end
            tpfr_pkg::TYPE_INT8:
            begin
                rd_ok  = in_item.elem_index < {3'b000, byte_cnt_reg};
                rd_off = {2'b00, b8_reg} + {2'b00, in_item.elem_index};
                nbytes = 3'd1;
            end
            tpfr_pkg::TYPE_INT16:
            begin
                rd_ok  = in_item.elem_index < {4'b0000, half_cnt_reg};
                rd_off = {2'b00, b16_reg} + {1'b0, in_item.elem_index, 1'b0};
                nbytes = 3'd2;
            end
            tpfr_pkg::TYPE_INT32:
            begin
                rd_ok  = in_item.elem_index < {5'b00000, word_cnt_reg};
                rd_off = {2'b00, b32_reg} + {in_item.elem_index, 2'b00};
                nbytes = 3'd4;
            end
            tpfr_pkg::TYPE_FP32:
            begin
                rd_ok  = in_item.elem_index < {5'b00000, float_cnt_reg};
                rd_off = {2'b00, bf_reg} + {in_item.elem_index, 2'b00};
                nbytes = 3'd4;
            end
            default: ;
        endcase
        for (int k = 0; k < 4; k++)
            rd_mask[k] = (3'(k) < nbytes) && ((rd_off + 13'(k)) < DEPTH13);
    end

    assign rd_addr = (acc_bank ? BANK_OFS : '0) + rd_off[AW-1:0];

    tpfr_payload_mem #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .AW            (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (en),
        .rd_addr (rd_addr),
        .rd_data (lane_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= accept;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // status is already none for reads since the parser only sees bytes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg   <= in_item.kind;
            s1_status_reg <= p_status;
            s1_ok_reg     <= rd_ok;
            s1_type_reg   <= in_item.elem_type;
            s1_bit_reg    <= in_item.elem_index[2:0];
            s1_lane_reg   <= rd_addr[1:0];
            s1_mask_reg   <= rd_mask;
            out_reg       <= '{status: s1_status_reg, value: value_c,
                               in_range: s1_kind_reg == tpfr_pkg::KIND_READ && s1_ok_reg};
        end
    end

    // value assembly from the lanes, big-endian
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            bytes_sel[k] = s1_mask_reg[k] ? lane_q[2'(s1_lane_reg + 2'(k))] : 8'h00;
        value_c = '0;
        case (s1_type_reg)
            tpfr_pkg::TYPE_BOOL:  value_c = {31'b0, bytes_sel[0][s1_bit_reg]};
            tpfr_pkg::TYPE_INT8:  value_c = {{24{bytes_sel[0][7]}}, bytes_sel[0]};
            tpfr_pkg::TYPE_INT16: value_c = {{16{bytes_sel[0][7]}}, bytes_sel[0],
                                             bytes_sel[1]};
            tpfr_pkg::TYPE_INT32,
            tpfr_pkg::TYPE_FP32:  value_c = {bytes_sel[0], bytes_sel[1],
                                             bytes_sel[2], bytes_sel[3]};
            default: ;
        endcase
        if (s1_kind_reg != tpfr_pkg::KIND_READ || !s1_ok_reg)
            value_c = '0;
    end

endmodule
`default_nettype wire
